### rtl/smstep_pkg.sv
// Shared types and codes for the stack machine step engine.
package smstep_pkg;

    localparam int unsigned OpW   = 4;
    localparam int unsigned WordW = 64;
    localparam int unsigned StatW = 3;
    localparam int unsigned LenW  = 11;

    typedef enum logic [OpW-1:0] {
        OP_NOP    = 4'd0,
        OP_PUSH   = 4'd1,
        OP_DUP    = 4'd2,
        OP_PLUS   = 4'd3,
        OP_MINUS  = 4'd4,
        OP_MULT   = 4'd5,
        OP_DIV    = 4'd6,
        OP_JMP    = 4'd7,
        OP_JMP_IF = 4'd8,
        OP_EQ     = 4'd9,
        OP_HALT   = 4'd10,
        OP_PRINT  = 4'd11
    } t_op;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_ILLEGAL   = 3'd3,
        ST_BAD_IP    = 3'd4,
        ST_BAD_ARG   = 3'd5,
        ST_DIV_ZERO  = 3'd6
    } t_status;

    // Divider handshake.
    typedef struct packed {
        logic             start;
        logic [WordW-1:0] dividend;
        logic [WordW-1:0] divisor;
    } t_div_req;

endpackage

### rtl/smstep_div.sv
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating.
module smstep_div
    import smstep_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [WordW-1:0] o_quot
);
    localparam int unsigned CntW = $clog2(WordW) + 1;

    logic             r_busy, n_busy;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [WordW-1:0] r_q, n_q;
    logic [WordW-1:0] r_rem, n_rem;
    logic [WordW-1:0] r_dvs, n_dvs;
    logic             r_neg, n_neg;
    logic             r_done, n_done;
    logic [WordW:0]   w_trial;
    logic [WordW:0]   w_shift;

    assign w_shift = {r_rem, r_q[WordW-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    // Load magnitudes, then restore-divide one bit per cycle.
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CntW'(WordW);
            n_q    = i_req.dividend[WordW-1] ? -i_req.dividend : i_req.dividend;
            n_dvs  = i_req.divisor[WordW-1] ? -i_req.divisor : i_req.divisor;
            n_rem  = '0;
            n_neg  = i_req.dividend[WordW-1] ^ i_req.divisor[WordW-1];
        end else if (r_busy) begin
            if (!w_trial[WordW]) begin
                n_rem = w_trial[WordW-1:0];
                n_q   = {r_q[WordW-2:0], 1'b1};
            end else begin
                n_rem = w_shift[WordW-1:0];
                n_q   = {r_q[WordW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -r_q : r_q;
endmodule

### rtl/stack_machine_step_top.sv
// Top level of the stack machine step engine: program store, value stack, sequencer.
//
//  channel | signals                                   | role
//  in      | i_valid, o_stall, i_req_type, i_write_*   | program write or execute request
//  out     | o_valid, i_stall, o_status .. o_print_*   | one result per request
//  cfg     | i_cfg_we, i_cfg_data                      | program_length register
//
// A write request goes from accept straight to the result. An execute runs accept, fetch from the
// program memory, a read of the top two stack entries, execute and write back, result;
// a bad pointer ends after the fetch. Multiplication adds steps for 32-bit partial products,
// and division waits on the iterative divider. One request
// is in flight at a time; o_stall stays high until the result is transferred.
// Reset is synchronous and clears pointer, depth, halt flag and the sequencer.
module stack_machine_step_top
    import smstep_pkg::*;
#(
    parameter int unsigned STACK_DEPTH   = 1024,
    parameter int unsigned PROGRAM_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    input  logic [9:0]        i_write_address,
    input  logic [OpW-1:0]    i_write_opcode,
    input  logic [WordW-1:0]  i_write_operand,
    input  logic              i_cfg_we,
    input  logic [LenW-1:0]   i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [StatW-1:0]  o_status,
    output logic              o_halted,
    output logic [WordW-1:0]  o_pointer_now,
    output logic [LenW-1:0]   o_depth_now,
    output logic              o_print_valid,
    output logic [WordW-1:0]  o_print_value
);
    localparam int unsigned PaW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int unsigned SaW = $clog2(STACK_DEPTH);
    localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_MUL   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Program and stack memories.
    logic [OpW-1:0]   r_pop [PROGRAM_DEPTH];
    logic [WordW-1:0] r_parg[PROGRAM_DEPTH];
    logic [WordW-1:0] r_stk [STACK_DEPTH];
    logic [OpW-1:0]   r_op_q;
    logic [WordW-1:0] r_arg_q;
    logic [WordW-1:0] r_rd_a, r_rd_b;

    logic [LenW-1:0]  r_plen;
    logic [WordW-1:0] r_ip;
    logic [DW-1:0]    r_depth;
    logic             r_halt;

    logic             p_we;
    logic             s_we;
    logic [SaW-1:0]   s_waddr;
    logic [WordW-1:0] s_wdata;
    logic [SaW-1:0]   s_raddr_a, s_raddr_b;

    logic [StatW-1:0] r_status, n_status;
    logic             r_pv, n_pv;
    logic [WordW-1:0] r_pval, n_pval;
    logic [WordW-1:0] n_ip;
    logic [DW-1:0]    n_depth;
    logic             n_halt;
    logic [1:0]       r_mstep, n_mstep;
    logic [WordW-1:0] r_macc, n_macc;

    logic             w_accept;
    logic             w_bad_ip;
    logic [LenW:0]    w_limit;
    logic [31:0]      w_mx, w_my;
    logic [WordW-1:0] w_mprod;
    t_div_req         w_div;
    logic             w_div_done;
    logic [WordW-1:0] w_quot;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign p_we     = w_accept && !i_req_type && ({1'b0, i_write_address} < 11'(PROGRAM_DEPTH));

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_plen <= '0;
        else if (i_cfg_we) r_plen <= i_cfg_data;
    end

    assign w_limit = ({1'b0, r_plen} < 12'(PROGRAM_DEPTH)) ? {1'b0, r_plen} : 12'(PROGRAM_DEPTH);
    assign w_bad_ip = r_ip[WordW-1] || (r_ip >= WordW'(w_limit));

    // Program memory: write on transfer, read at the pointer.
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pop[PaW'(i_write_address)]  <= i_write_opcode;
            r_parg[PaW'(i_write_address)] <= i_write_operand;
        end
        r_op_q  <= r_pop[PaW'(r_ip)];
        r_arg_q <= r_parg[PaW'(r_ip)];
    end

    // Stack read addresses: top, and top-1 or the dup source.
    always_comb begin
        s_raddr_a = SaW'(r_depth - 1'b1);
        if (t_op'(r_op_q) == OP_DUP) s_raddr_b = SaW'(r_depth - 1'b1 - DW'(r_arg_q));
        else                         s_raddr_b = SaW'(r_depth - 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (s_we) r_stk[s_waddr] <= s_wdata;
        r_rd_a <= r_stk[s_raddr_a];
        r_rd_b <= r_stk[s_raddr_b];
    end

    // Pick the 32-bit halves for the current partial product.
    always_comb begin
        case (r_mstep)
            2'd0: begin
                w_mx = r_rd_b[31:0];
                w_my = r_rd_a[31:0];
            end
            2'd1: begin
                w_mx = r_rd_b[31:0];
                w_my = r_rd_a[63:32];
            end
            default: begin
                w_mx = r_rd_b[63:32];
                w_my = r_rd_a[31:0];
            end
        endcase
    end

    assign w_mprod = w_mx * w_my;

    assign w_div.start    = (r_state == S_EXEC) && (t_op'(r_op_q) == OP_DIV) &&
                            (r_depth >= DW'(2)) && (r_rd_a != '0);
    assign w_div.dividend = r_rd_b;
    assign w_div.divisor  = r_rd_a;

    smstep_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // Sequencer and execute.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_pv     = r_pv;
        n_pval   = r_pval;
        n_ip     = r_ip;
        n_depth  = r_depth;
        n_halt   = r_halt;
        n_mstep  = r_mstep;
        n_macc   = r_macc;
        s_we     = 1'b0;
        s_waddr  = SaW'(r_depth);
        s_wdata  = r_arg_q;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_pv     = 1'b0;
                    n_pval   = '0;
                    if (!i_req_type)  n_state = S_OUT;
                    else              n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (w_bad_ip) begin
                    n_status = ST_BAD_IP;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_OUT;
                case (r_op_q)
                    OP_NOP: n_ip = r_ip + 1'b1;
                    OP_PUSH: begin
                        if (r_depth >= DW'(STACK_DEPTH)) n_status = ST_OVERFLOW;
                        else begin
                            s_we    = 1'b1;
                            n_depth = r_depth + 1'b1;
                            n_ip    = r_ip + 1'b1;
                        end
                    end
                    OP_DUP: begin
                        if (!r_arg_q[WordW-1] && r_arg_q >= WordW'(r_depth))
                            n_status = ST_UNDERFLOW;
                        else if (r_depth >= DW'(STACK_DEPTH)) n_status = ST_OVERFLOW;
                        else if (r_arg_q[WordW-1]) n_status = ST_BAD_ARG;
                        else begin
                            s_we    = 1'b1;
                            s_wdata = r_rd_b;
                            n_depth = r_depth + 1'b1;
                            n_ip    = r_ip + 1'b1;
                        end
                    end
                    OP_PLUS, OP_MINUS, OP_MULT, OP_DIV, OP_EQ: begin
                        s_waddr = SaW'(r_depth - 2'd2);
                        if (r_depth < DW'(2)) n_status = ST_UNDERFLOW;
                        else if (r_op_q == OP_DIV) begin
                            if (r_rd_a == '0) n_status = ST_DIV_ZERO;
                            else n_state = S_DIV;
                        end else if (r_op_q == OP_MULT) begin
                            n_state = S_MUL;
                            n_mstep = 2'd0;
                            n_macc  = '0;
                        end else begin
                            s_we    = 1'b1;
                            n_depth = r_depth - 1'b1;
                            n_ip    = r_ip + 1'b1;
                            case (r_op_q)
                                OP_PLUS:  s_wdata = r_rd_b + r_rd_a;
                                OP_MINUS: s_wdata = r_rd_b - r_rd_a;
                                default:  s_wdata = WordW'(r_rd_b == r_rd_a);
                            endcase
                        end
                    end
                    OP_JMP: n_ip = r_arg_q;
                    OP_JMP_IF: begin
                        if (r_depth < DW'(1)) n_status = ST_UNDERFLOW;
                        else if (r_rd_a != '0) begin
                            n_depth = r_depth - 1'b1;
                            n_ip    = r_arg_q;
                        end else n_ip = r_ip + 1'b1;
                    end
                    OP_HALT: n_halt = 1'b1;
                    OP_PRINT: begin
                        if (r_depth < DW'(1)) n_status = ST_UNDERFLOW;
                        else begin
                            n_pv    = 1'b1;
                            n_pval  = r_rd_a;
                            n_depth = r_depth - 1'b1;
                            n_ip    = r_ip + 1'b1;
                        end
                    end
                    default: n_status = ST_ILLEGAL;
                endcase
            end
            // Accumulate low x low, then both cross terms into the upper half.
            S_MUL: begin
                s_waddr = SaW'(r_depth - 2'd2);
                s_wdata = r_macc + {w_mprod[31:0], 32'd0};
                if (r_mstep == 2'd0) begin
                    n_macc  = w_mprod;
                    n_mstep = 2'd1;
                end else if (r_mstep == 2'd1) begin
                    n_macc  = r_macc + {w_mprod[31:0], 32'd0};
                    n_mstep = 2'd2;
                end else begin
                    s_we    = 1'b1;
                    n_depth = r_depth - 1'b1;
                    n_ip    = r_ip + 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                s_waddr = SaW'(r_depth - 2'd2);
                s_wdata = w_quot;
                if (w_div_done) begin
                    s_we    = 1'b1;
                    n_depth = r_depth - 1'b1;
                    n_ip    = r_ip + 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ip    <= '0;
            r_depth <= '0;
            r_halt  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ip    <= n_ip;
            r_depth <= n_depth;
            r_halt  <= n_halt;
        end
        r_status <= n_status;
        r_pv     <= n_pv;
        r_pval   <= n_pval;
        r_mstep  <= n_mstep;
        r_macc   <= n_macc;
    end

    assign o_valid       = (r_state == S_OUT);
    assign o_status      = r_status;
    assign o_halted      = r_halt;
    assign o_pointer_now = r_ip;
    assign o_depth_now   = LenW'(r_depth);
    assign o_print_valid = r_pv;
    assign o_print_value = r_pval;
endmodule

### test/smstep_checker.sv
// Checker for the stack machine step engine: predicts each result and compares it.
module smstep_checker
    import smstep_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_in_stall,
    input  logic              i_req_type,
    input  logic [9:0]        i_write_address,
    input  logic [OpW-1:0]    i_write_opcode,
    input  logic [WordW-1:0]  i_write_operand,
    input  logic              i_cfg_we,
    input  logic [LenW-1:0]   i_cfg_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [StatW-1:0]  i_status,
    input  logic              i_halted,
    input  logic [WordW-1:0]  i_pointer_now,
    input  logic [LenW-1:0]   i_depth_now,
    input  logic              i_print_valid,
    input  logic [WordW-1:0]  i_print_value,
    output int                o_pending,
    output logic [WordW-1:0]  o_ip,
    output int                o_depth,
    output int                o_fail_count
);

    localparam int unsigned NumWords = 1024;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic             halted;
        logic [WordW-1:0] pointer_now;
        logic [LenW-1:0]  depth_now;
        logic             print_valid;
        logic [WordW-1:0] print_value;
    } t_result;

    // Predicted machine state
    logic [OpW-1:0]   code_op    [NumWords];
    logic [WordW-1:0] code_arg   [NumWords];
    logic [WordW-1:0] value_stk  [NumWords];
    int unsigned      stk_depth;
    logic [WordW-1:0] ip;
    logic             halt_flag;
    logic [LenW-1:0]  prog_len;
    t_result          result_q   [$];
    int               fails;

    // Apply one request to the predicted state and return the result it gives.
    function t_result apply_request(input logic is_exec, input logic [9:0] addr,
                                    input logic [OpW-1:0] wop, input logic [WordW-1:0] warg);
        t_result          r;
        logic [WordW-1:0] lim;
        logic [WordW-1:0] arg;
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        logic [OpW-1:0]   op;
        r   = '0;
        lim = (prog_len < NumWords) ? WordW'(prog_len) : WordW'(NumWords);
        if (!is_exec) begin
            code_op[addr]  = wop;
            code_arg[addr] = warg;
        end else if (ip[WordW-1] || ip >= lim) begin
            r.status = ST_BAD_IP;
        end else begin
            op  = code_op[ip[9:0]];
            arg = code_arg[ip[9:0]];
            case (op)
                OP_NOP: ip = ip + 1;
                OP_PUSH: begin
                    if (stk_depth >= NumWords) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        value_stk[stk_depth] = arg;
                        stk_depth++;
                        ip = ip + 1;
                    end
                end
                OP_DUP: begin
                    if (!arg[WordW-1] && arg >= WordW'(stk_depth)) r.status = ST_UNDERFLOW;
                    else if (stk_depth >= NumWords) r.status = ST_OVERFLOW;
                    else if (arg[WordW-1]) r.status = ST_BAD_ARG;
                    else begin
                        value_stk[stk_depth] = value_stk[stk_depth - 1 - int'(arg)];
                        stk_depth++;
                        ip = ip + 1;
                    end
                end
                OP_PLUS, OP_MINUS, OP_MULT, OP_DIV, OP_EQ: begin
                    if (stk_depth < 2) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        a = value_stk[stk_depth-2];
                        b = value_stk[stk_depth-1];
                        if (op == OP_DIV && b == '0) begin
                            r.status = ST_DIV_ZERO;
                        end else begin
                            case (op)
                                OP_PLUS:  a = a + b;
                                OP_MINUS: a = a - b;
                                OP_MULT:  a = a * b;
                                OP_DIV: begin
                                    // most negative over minus one wraps to itself
                                    if (!(a == {1'b1, {(WordW-1){1'b0}}} && b == '1))
                                        a = $signed(a) / $signed(b);
                                end
                                default:  a = (a == b) ? WordW'(1) : '0;
                            endcase
                            value_stk[stk_depth-2] = a;
                            stk_depth--;
                            ip = ip + 1;
                        end
                    end
                end
                OP_JMP: ip = arg;
                OP_JMP_IF: begin
                    if (stk_depth < 1) r.status = ST_UNDERFLOW;
                    else if (value_stk[stk_depth-1] != '0) begin
                        stk_depth--;
                        ip = arg;
                    end else begin
                        ip = ip + 1;
                    end
                end
                OP_HALT: halt_flag = 1'b1;
                OP_PRINT: begin
                    if (stk_depth < 1) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        r.print_valid = 1'b1;
                        r.print_value = value_stk[stk_depth-1];
                        stk_depth--;
                        ip = ip + 1;
                    end
                end
                default: r.status = ST_ILLEGAL;
            endcase
        end
        r.halted      = halt_flag;
        r.pointer_now = ip;
        r.depth_now   = LenW'(stk_depth);
        return r;
    endfunction

    function void check_field(input string name, input logic [WordW-1:0] want,
                              input logic [WordW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    // Compare transfers on the result side, then predict transfers on the request side.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            stk_depth = 0;
            ip        = '0;
            halt_flag = 1'b0;
            prog_len  = '0;
            fails     = 0;
            result_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with no result expected");
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    check_field("status", WordW'(want.status), WordW'(i_status));
                    check_field("halted", WordW'(want.halted), WordW'(i_halted));
                    check_field("pointer_now", want.pointer_now, i_pointer_now);
                    check_field("depth_now", WordW'(want.depth_now), WordW'(i_depth_now));
                    check_field("print_valid", WordW'(want.print_valid), WordW'(i_print_valid));
                    check_field("print_value", want.print_value, i_print_value);
                end
            end
            if (i_valid && !i_in_stall)
                result_q.push_back(apply_request(i_req_type, i_write_address,
                                                 i_write_opcode, i_write_operand));
            if (i_cfg_we)
                prog_len = i_cfg_data;
        end
        o_pending    = result_q.size();
        o_ip         = ip;
        o_depth      = stk_depth;
        o_fail_count = fails;
    end

endmodule

### test/stack_machine_step_top_test.sv
// Testbench top for the stack machine step engine: stimulus, idling and verdict.
module stack_machine_step_top_test;
    import smstep_pkg::*;

    localparam int unsigned NumWords  = 1024;
    localparam int          IdleLimit = 4000;
    localparam logic [OpW-1:0] OP_ILLEGAL_HI = 4'hF;
    localparam logic [WordW-1:0] WORD_MAX = {1'b0, {(WordW-1){1'b1}}};
    localparam logic [WordW-1:0] WORD_MIN = {1'b1, {(WordW-1){1'b0}}};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic             i_req_type;
    logic [9:0]       i_write_address;
    logic [OpW-1:0]   i_write_opcode;
    logic [WordW-1:0] i_write_operand;
    logic             i_cfg_we;
    logic [LenW-1:0]  i_cfg_data;
    logic             o_valid;
    logic             i_stall;
    logic [StatW-1:0] o_status;
    logic             o_halted;
    logic [WordW-1:0] o_pointer_now;
    logic [LenW-1:0]  o_depth_now;
    logic             o_print_valid;
    logic [WordW-1:0] o_print_value;

    int               pending;
    logic [WordW-1:0] pred_ip;
    int               pred_depth;
    int               fail_count;
    int               idle_cycles;
    int               burst_left;
    int               cur_len;
    logic [NumWords-1:0] written;

    stack_machine_step_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_write_address(i_write_address),
        .i_write_opcode(i_write_opcode), .i_write_operand(i_write_operand),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .o_valid(o_valid),
        .i_stall(i_stall), .o_status(o_status), .o_halted(o_halted),
        .o_pointer_now(o_pointer_now), .o_depth_now(o_depth_now),
        .o_print_valid(o_print_valid), .o_print_value(o_print_value)
    );

    smstep_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_req_type(i_req_type), .i_write_address(i_write_address),
        .i_write_opcode(i_write_opcode), .i_write_operand(i_write_operand),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_status(o_status), .i_halted(o_halted),
        .i_pointer_now(o_pointer_now), .i_depth_now(o_depth_now),
        .i_print_valid(o_print_valid), .i_print_value(o_print_value),
        .o_pending(pending), .o_ip(pred_ip), .o_depth(pred_depth),
        .o_fail_count(fail_count)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stall, one pattern per stretch
    initial begin
        int mode;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(16, 80)) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= 1'($urandom_range(0, 1));
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Drive one request and hold it until transferred; gap between bursts.
    task automatic send(input logic rt, input logic [9:0] addr, input logic [OpW-1:0] op,
                        input logic [WordW-1:0] arg);
        i_valid         <= 1'b1;
        i_req_type      <= rt;
        i_write_address <= addr;
        i_write_opcode  <= op;
        i_write_operand <= arg;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if (!rt) written[addr] = 1'b1;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
        end
    endtask

    task automatic exec_step();
        send(1'b1, 10'($urandom), OpW'($urandom), {$urandom, $urandom});
    endtask

    // Write the register once the engine has drained
    task automatic set_len(input int n);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= LenW'(n);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_len = n;
    endtask

    // Pick a random instruction; jump targets stay inside program memory
    task automatic write_random(input logic [9:0] addr);
        logic [OpW-1:0]   op;
        logic [WordW-1:0] arg;
        longint           sv;
        int               w;
        int               k;
        w   = $urandom_range(0, 99);
        arg = {$urandom, $urandom};
        if (w < 25) op = OP_PUSH;
        else if (w < 35) op = OP_DUP;
        else if (w < 40) op = OP_PLUS;
        else if (w < 45) op = OP_MINUS;
        else if (w < 50) op = OP_MULT;
        else if (w < 56) op = OP_DIV;
        else if (w < 62) op = OP_JMP;
        else if (w < 70) op = OP_JMP_IF;
        else if (w < 75) op = OP_EQ;
        else if (w < 85) op = OP_PRINT;
        else if (w < 89) op = OP_NOP;
        else if (w < 91) op = OP_HALT;
        else op = OpW'($urandom_range(12, 15));
        // last word must jump back, or the pointer runs off the end for good
        if (addr == 10'(NumWords - 1)) op = OP_JMP;
        k = $urandom_range(0, 9);
        case (op)
            OP_PUSH: begin
                if (k >= 4 && k <= 6) begin
                    sv  = longint'($urandom_range(0, 8)) - 4;
                    arg = sv;
                end else if (k == 7) arg = WORD_MAX;
                else if (k == 8) arg = WORD_MIN;
                else if (k == 9) arg = '0;
            end
            OP_DUP: begin
                if (k < 8) arg = WordW'($urandom_range(0, pred_depth + 1));
                else if (k == 8) arg[WordW-1] = 1'b1;
                else arg[WordW-1] = 1'b0;
            end
            OP_JMP, OP_JMP_IF: begin
                if (k < 9 && cur_len > 0) arg = WordW'($urandom_range(0, cur_len - 1));
                else arg = WordW'($urandom_range(0, NumWords - 1));
            end
            default: ;
        endcase
        send(1'b0, addr, op, arg);
    endtask

    // Directed: place an instruction at the pointer and run it
    task automatic run_at_ip(input logic [OpW-1:0] op, input logic [WordW-1:0] arg);
        send(1'b0, pred_ip[9:0], op, arg);
        exec_step();
    endtask

    // One random request, steered by the predicted pointer
    task automatic random_item();
        int r;
        r = $urandom_range(0, 19);
        if (pred_ip[WordW-1] || pred_ip >= WordW'(cur_len)) begin
            if (r < 7) exec_step();
            else write_random(10'($urandom_range(0, NumWords - 1)));
        end else if (!written[pred_ip[9:0]]) begin
            write_random(pred_ip[9:0]);
        end else if (r < 14) begin
            exec_step();
        end else if (r < 17) begin
            write_random(pred_ip[9:0]);
        end else begin
            write_random(10'($urandom_range(0, cur_len - 1)));
        end
    endtask

    initial begin
        int phase_len [7];
        phase_len = '{8, 1, 0, 40, 1024, 3, 200};
        written         = '0;
        burst_left      = 0;
        cur_len         = 0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_req_type      = 1'b0;
        i_write_address = '0;
        i_write_opcode  = '0;
        i_write_operand = '0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty program, wraps, division corners, error checks
        exec_step();
        set_len(64);
        run_at_ip(OP_PUSH, WORD_MAX);
        run_at_ip(OP_PUSH, WordW'(1));
        run_at_ip(OP_PLUS, '0);
        run_at_ip(OP_PUSH, '1);
        run_at_ip(OP_DIV, '0);
        run_at_ip(OP_PUSH, '0);
        run_at_ip(OP_DIV, '0);
        run_at_ip(OP_EQ, '0);
        run_at_ip(OP_JMP_IF, '0);
        run_at_ip(OP_DUP, '1);
        run_at_ip(OP_DUP, WordW'(5));
        run_at_ip(OP_PRINT, '0);
        run_at_ip(OP_PRINT, '0);
        run_at_ip(OP_ILLEGAL_HI, '0);
        run_at_ip(OP_HALT, '0);
        run_at_ip(OP_JMP, pred_ip + 1);

        // Random phases over several program lengths
        foreach (phase_len[p]) begin
            set_len(phase_len[p]);
            repeat (140) random_item();
        end

        set_len(NumWords);
        repeat (80) random_item();

        // A negative jump target leaves the pointer out of range for good
        if (!pred_ip[WordW-1] && pred_ip < WordW'(cur_len)) begin
            send(1'b0, pred_ip[9:0], OP_JMP, {1'b1, 59'd0, 4'd5});
            exec_step();
            exec_step();
        end

        // Drain and give the verdict
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
